// ===== sv/apd_pkg.sv =====
package apd_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_D      = 3'd1;
  localparam logic [2:0] REG_STEP_TIME   = 3'd2;
  localparam logic [2:0] REG_DEADBAND    = 3'd3;
  localparam logic [2:0] REG_WRAP_ENABLE = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int ERR_W  = 18;  // wrapped error, 1/64 units
  localparam int MUL_AW = 19;  // signed operand of the shared multiplier
  localparam int MUL_BW = 24;  // unsigned operand of the shared multiplier
  localparam int MUL_PW = 44;  // signed product
  localparam int ACC_W  = 45;  // numerator accumulator

  localparam logic signed [ERR_W-1:0] HALF_TURN = 18'sd11520;
  localparam logic signed [ERR_W-1:0] FULL_TURN = 18'sd23040;
  localparam logic [7:0] DRIVE_MAX     = 8'd255;
  localparam logic [7:0] DRIVE_NEUTRAL = 8'd127;
  localparam logic [7:0] DRIVE_MIN     = 8'd0;

  localparam logic [15:0] GAIN_P_RST   = 16'd205;
  localparam logic [23:0] GAIN_D_RST   = 24'd51200;
  localparam logic [7:0]  STEP_RST     = 8'd5;
  localparam logic [14:0] DEADBAND_RST = 15'd128;
  localparam logic signed [ERR_W-1:0] PREV_ERR_RST = 18'sd64;

  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic [7:0]         bias_drive;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive;
    logic       in_deadband;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/apd_mul.sv =====
module apd_mul (
  input  logic                                clk,
  input  logic signed [apd_pkg::MUL_AW-1:0]   mul_a,
  input  logic        [apd_pkg::MUL_BW-1:0]   mul_b,
  output logic signed [apd_pkg::MUL_PW-1:0]   prod_r
);
  import apd_pkg::*;

  logic signed [MUL_AW+MUL_BW:0] prod_full;

  // signed by unsigned: zero-extend b so it multiplies as a signed value
  assign prod_full = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    prod_r <= prod_full[MUL_PW-1:0];
  end

endmodule

// ===== sv/apd_div.sv =====
module apd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         dividend,
  input  logic [7:0]          divisor,
  output logic [7:0]          quotient,
  output apd_pkg::div_stat_t  stat
);
  import apd_pkg::*;

  // Quotient is known to fit 8 bits, so the remainder starts from the
  // upper byte of the dividend and eight restoring steps finish it.
  logic       run_r, run_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] low_r, low_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [8:0] trial;
  logic       fits;

  assign trial = {rem_r, low_r[7]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 3'd0;
      rem_nxt = dividend[15:8];
      low_nxt = dividend[7:0];
    end else if (run_r) begin
      rem_nxt = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      low_nxt = {low_r[6:0], 1'b0};
      quo_nxt = {quo_r[6:0], fits};
      cnt_nxt = 3'(cnt_r + 3'd1);
      if (cnt_r == 3'd7) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// ===== sv/angle_pd_controller.sv =====
// PD drive controller with deadband. One item (measured, target, bias_drive)
// gives one result (drive, in_deadband). The error measured - target is
// wrapped once by 360 degrees when wrap_enable is set; an error within the
// deadband gives the neutral drive 127 and leaves the stored error alone.
// Otherwise the drive is the truncated value of
// (P*e*t + D*(e - e_prev) + 16384*t*bias) / (16384*t), clamped to 0..255.
// An item in the deadband goes from acceptance through S_ERR and S_DB to the
// result register; one whose drive clamps to 0 or 255 also makes four passes
// through the one shared 19x24 multiplier; any other item then runs the
// 8-step serial divider too. in_ready is high only while the sequencer is
// idle; a finished result waits in the output register, so the next item may
// be accepted before the last is taken. The user writes configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module angle_pd_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  apd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output apd_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import apd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;  // form and wrap the error
  localparam logic [3:0] S_DB   = 4'd2;  // deadband check, issue P*t
  localparam logic [3:0] S_M1   = 4'd3;  // issue e*(P*t)
  localparam logic [3:0] S_M2   = 4'd4;  // load e*P*t, issue d*D
  localparam logic [3:0] S_M3   = 4'd5;  // add d*D, issue bias*t
  localparam logic [3:0] S_M4   = 4'd6;  // add bias*t*16384
  localparam logic [3:0] S_CHK  = 4'd7;  // sign and saturation, start divide
  localparam logic [3:0] S_DIV  = 4'd8;  // wait for the quotient
  localparam logic [3:0] S_OUT  = 4'd9;  // hand the result to the output stage

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [15:0] gain_p_r;
  logic [23:0] gain_d_r;
  logic [7:0]  step_r;
  logic [14:0] db_r;
  logic        wrap_r;

  in_item_t                 item_r, item_nxt;
  logic signed [ERR_W-1:0]  e_r, e_nxt;
  logic signed [ERR_W-1:0]  prev_r, prev_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  out_item_t                res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [7:0]               t_eff;
  logic signed [ERR_W-1:0]  diff;
  logic [ERR_W-1:0]         mag;
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic signed [MUL_PW-1:0] prod_r;
  logic signed [MUL_AW-1:0] d_err;
  logic [ACC_W-15:0]        num_hi;
  logic                     sat;
  logic                     div_start;
  logic [7:0]               quotient;
  div_stat_t                div_stat;

  function automatic logic signed [ERR_W-1:0] in_item_sext(input logic signed [15:0] v);
    in_item_sext = {{(ERR_W-16){v[15]}}, v};
  endfunction

  // a step time of zero counts as one
  assign t_eff = (step_r == 8'd0) ? 8'd1 : step_r;

  assign diff  = ERR_W'(in_item_sext(item_r.measured)) - ERR_W'(in_item_sext(item_r.target));
  assign mag   = e_r[ERR_W-1] ? ERR_W'(-e_r) : e_r;
  assign d_err = {e_r[ERR_W-1], e_r} - {prev_r[ERR_W-1], prev_r};

  // numerator divided by 16384; the remaining divide is by t alone
  assign num_hi = acc_r[ACC_W-1:14];
  assign sat    = (num_hi[ACC_W-15:16] != '0) || (num_hi[15:0] >= {t_eff, 8'h00});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DB: begin
        mul_a = {3'b000, gain_p_r};
        mul_b = {16'h0000, t_eff};
      end
      S_M1: begin
        mul_a = {e_r[ERR_W-1], e_r};
        mul_b = prod_r[MUL_BW-1:0];
      end
      S_M2: begin
        mul_a = d_err;
        mul_b = gain_d_r;
      end
      S_M3: begin
        mul_a = {11'h000, item_r.bias_drive};
        mul_b = {16'h0000, t_eff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  apd_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  apd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_hi[15:0]),
    .divisor  (t_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    e_nxt         = e_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    // drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        e_nxt = diff;
        if (wrap_r) begin
          if (diff > HALF_TURN) begin
            e_nxt = diff - FULL_TURN;
          end else if (diff < -HALF_TURN) begin
            e_nxt = diff + FULL_TURN;
          end
        end
        state_nxt = S_DB;
      end
      S_DB: begin
        if (mag <= {3'b000, db_r}) begin
          res_nxt.drive       = DRIVE_NEUTRAL;
          res_nxt.in_deadband = 1'b1;
          state_nxt           = S_OUT;
        end else begin
          res_nxt.in_deadband = 1'b0;
          state_nxt           = S_M1;
        end
      end
      S_M1: begin
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt   = {prod_r[MUL_PW-1], prod_r};
        state_nxt = S_M3;
      end
      S_M3: begin
        acc_nxt   = acc_r + {prod_r[MUL_PW-1], prod_r};
        state_nxt = S_M4;
      end
      S_M4: begin
        acc_nxt   = acc_r + {15'h0000, prod_r[15:0], 14'h0000};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        prev_nxt = e_r;
        if (acc_r[ACC_W-1]) begin
          res_nxt.drive = DRIVE_MIN;
          state_nxt     = S_OUT;
        end else if (sat) begin
          res_nxt.drive = DRIVE_MAX;
          state_nxt     = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_nxt.drive = quotient;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= PREV_ERR_RST;
      gain_p_r    <= GAIN_P_RST;
      gain_d_r    <= GAIN_D_RST;
      step_r      <= STEP_RST;
      db_r        <= DEADBAND_RST;
      wrap_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P:      gain_p_r <= cfg_wdata[15:0];
          REG_GAIN_D:      gain_d_r <= cfg_wdata[23:0];
          REG_STEP_TIME:   step_r   <= cfg_wdata[7:0];
          REG_DEADBAND:    db_r     <= cfg_wdata[14:0];
          REG_WRAP_ENABLE: wrap_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    item_r     <= item_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/apd_checker.sv =====
module apd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input apd_pkg::out_item_t  out_data
);
  import apd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted item keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // deadband results carry the neutral drive
  a_deadband_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_deadband |-> out_data.drive == DRIVE_NEUTRAL)
    else $error("deadband result without neutral drive");

  // a new result is only loaded by a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind angle_pd_controller apd_checker u_apd_checker (.*);

// ===== tb/angle_pd_controller_tb.sv =====
module angle_pd_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apd_pkg::*;

  // Denominator scale of the Q2.14 / Q10.14 gain products
  localparam longint DRIVE_SCALE = 16384;
  // Long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles to let pass after the last result
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 123;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef enum int {
    ERR_WALK,
    ERR_DEADBAND_EDGE,
    ERR_WRAP_EDGE,
    ERR_ANY
  } err_class_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and of the stored error
  logic [15:0] p_gain = GAIN_P_RST;
  logic [23:0] d_gain = GAIN_D_RST;
  logic [7:0] tick_ms = STEP_RST;
  logic [14:0] dead_zone = DEADBAND_RST;
  logic wrap_on = 1'b1;
  logic signed [ERR_W-1:0] err_prev = PREV_ERR_RST;

  in_item_t pending_ticks[$];
  out_item_t expected_drives[$];
  int fail_count = 0;
  // Items taken off the pending queue whose result has not been taken yet
  int in_flight = 0;

  // Sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // Receiver state; hold_token is bumped by the stimulus to request a hold-off
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int rx_tick = 0;
  rx_mode_e rx_mode = RX_OPEN;

  // Random-walk error for well-behaved control sequences
  int walk_err = 0;
  out_item_t want;

  angle_pd_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Work out the drive for one control tick and advance the stored error.
  function automatic out_item_t drive_for(input in_item_t it);
    longint err;
    longint mag;
    longint ticks;
    longint den;
    longint num;
    longint q;
    out_item_t res;
    err = longint'($signed(it.measured)) - longint'($signed(it.target));
    // Wrap once only; a result still beyond half a turn stands as it is
    if (wrap_on) begin
      if (err > longint'(HALF_TURN)) begin
        err -= longint'(FULL_TURN);
      end else if (err < -longint'(HALF_TURN)) begin
        err += longint'(FULL_TURN);
      end
    end
    mag = (err < 0) ? -err : err;
    // Inside the deadband: neutral drive, keep the stored error
    if (mag <= longint'(dead_zone)) begin
      res.drive = DRIVE_NEUTRAL;
      res.in_deadband = 1'b1;
      return res;
    end
    ticks = (tick_ms == 8'd0) ? 1 : longint'(tick_ms);
    den = DRIVE_SCALE * ticks;
    num = err * longint'(p_gain) * ticks
        + (err - longint'(err_prev)) * longint'(d_gain)
        + longint'(it.bias_drive) * den;
    // Negative drive clamps to zero, otherwise truncate and saturate
    if (num < 0) begin
      q = 0;
    end else begin
      q = num / den;
      if (q > longint'(DRIVE_MAX)) q = longint'(DRIVE_MAX);
    end
    err_prev = err[ERR_W-1:0];
    res.drive = q[7:0];
    res.in_deadband = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Build an item whose raw error is err, with measured placed at random.
  function automatic in_item_t item_for_error(input int err, input logic [7:0] bias);
    int lo;
    int hi;
    int m;
    int t;
    in_item_t it;
    lo = (err > 0) ? -32768 + err : -32768;
    hi = (err < 0) ? 32767 + err : 32767;
    m = lo + int'($urandom_range(0, hi - lo));
    t = m - err;
    it.measured = m[15:0];
    it.target = t[15:0];
    it.bias_drive = bias;
    return it;
  endfunction

  function automatic in_item_t next_random_item();
    int r;
    int err;
    logic [7:0] bias;
    err_class_e pick;
    in_item_t it;
    r = $urandom_range(0, 7);
    if (r == 0) bias = 8'd0;
    else if (r == 1) bias = 8'd255;
    else bias = 8'($urandom_range(0, 255));

    r = $urandom_range(0, 99);
    if (r < 50) pick = ERR_WALK;
    else if (r < 70) pick = ERR_DEADBAND_EDGE;
    else if (r < 85) pick = ERR_WRAP_EDGE;
    else pick = ERR_ANY;

    case (pick)
      ERR_WALK: begin
        // Drift like a real control loop, with an occasional jump
        if ($urandom_range(0, 15) == 0) begin
          walk_err = int'($urandom_range(0, 4000)) - 2000;
        end else begin
          walk_err += int'($urandom_range(0, 64)) - 32;
        end
        if (walk_err > 65535) walk_err = 65535;
        if (walk_err < -65535) walk_err = -65535;
        err = walk_err;
      end
      ERR_DEADBAND_EDGE: begin
        err = int'(dead_zone) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) err = -err;
      end
      ERR_WRAP_EDGE: begin
        r = $urandom_range(0, 2);
        err = (r == 0) ? 11520 : (r == 1) ? 23040 : 34560;
        err += int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) err = -err;
      end
      default: begin
        it.measured = 16'($urandom_range(0, 65535));
        it.target = 16'($urandom_range(0, 65535));
        it.bias_drive = bias;
        return it;
      end
    endcase
    return item_for_error(err, bias);
  endfunction

  task automatic queue_pair(input int m, input int t, input int b);
    in_item_t it;
    it.measured = m[15:0];
    it.target = t[15:0];
    it.bias_drive = b[7:0];
    pending_ticks = {pending_ticks, it};
  endtask

  // Write one register and mirror it into the predictor; the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GAIN_P:      p_gain = val[15:0];
      REG_GAIN_D:      d_gain = val[23:0];
      REG_STEP_TIME:   tick_ms = val[7:0];
      REG_DEADBAND:    dead_zone = val[14:0];
      REG_WRAP_ENABLE: wrap_on = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int gp, input int gd, input int st,
                              input int db, input int wr);
    write_reg(REG_GAIN_P, 24'(gp));
    write_reg(REG_GAIN_D, 24'(gd));
    write_reg(REG_STEP_TIME, 24'(st));
    write_reg(REG_DEADBAND, 24'(db));
    write_reg(REG_WRAP_ENABLE, 24'(wr));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the stimulus until every queued item is in and every result is out,
  // then let the block settle before anything touches its registers.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: offer items from the pending queue in bursts with random gaps.
  // Predict each item at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_drives = {expected_drives, drive_for(in_data)};
      end
      // Only move on once the current item is gone; otherwise hold it
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_data <= pending_ticks.pop_front();
          in_flight++;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Pick the next burst; now and then a long run without gaps
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(40, 120);
            else burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3, 4, 5: gap_left = $urandom_range(1, 8);
              6:       gap_left = $urandom_range(9, 30);
              default: gap_left = $urandom_range(31, 60);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern that changes mode every so often, and hold
  // off for a long stretch whenever the stimulus asks for it.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= ((rx_tick % 5) < 2);
      endcase
      rx_tick++;
    end
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected result drive=%0d in_deadband=%0b",
                                  out_data.drive, out_data.in_deadband));
      end else begin
        want = expected_drives.pop_front();
        in_flight--;
        if (out_data.drive !== want.drive) begin
          report_mismatch($sformatf("drive %0d, predicted %0d",
                                    out_data.drive, want.drive));
        end
        if (out_data.in_deadband !== want.in_deadband) begin
          report_mismatch($sformatf("in_deadband %0b, predicted %0b",
                                    out_data.in_deadband, want.in_deadband));
        end
      end
    end
  end

  initial begin : stimulus
    int gp;
    int gd;
    int st;
    int db;
    int wr;

    // Hold reset, then release it for good
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: deadband edges, wrap thresholds, double wrap, extremes
    queue_pair(0, 0, 100);
    queue_pair(128, 0, 0);
    queue_pair(-128, 0, 255);
    queue_pair(129, 0, 128);
    queue_pair(0, 129, 128);
    queue_pair(11520, 0, 50);
    queue_pair(11521, 0, 50);
    queue_pair(-11520, 0, 50);
    queue_pair(0, 11521, 50);
    queue_pair(32767, -32768, 255);
    queue_pair(-32768, 32767, 0);
    queue_pair(-32768, -32768, 255);
    queue_pair(32767, 32767, 0);
    queue_pair(500, 0, 255);
    wait_drained();

    // Top gains, shortest tick, no deadband, linear error
    program_regs(65535, 24'hFFFFFF, 1, 0, 0);
    queue_pair(0, 0, 0);
    queue_pair(1, 0, 0);
    queue_pair(0, 1, 255);
    queue_pair(11521, 0, 7);
    queue_pair(32767, -32768, 0);
    queue_pair(-32768, 32767, 255);
    wait_drained();

    // Zero gains, longest tick, widest deadband, wrapped error
    program_regs(0, 0, 255, 32767, 1);
    queue_pair(32767, -32768, 200);
    queue_pair(-32768, 32767, 0);
    queue_pair(32767, 0, 9);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Mostly gains that keep the drive off the rails, now and then any value
      gp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, 1024);
      gd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                       : $urandom_range(0, 200000);
      case ($urandom_range(0, 3))
        0:       st = 1;
        1:       st = 255;
        default: st = $urandom_range(1, 255);
      endcase
      db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                       : $urandom_range(0, 600);
      wr = $urandom_range(0, 1);
      program_regs(gp, gd, st, db, wr);

      // Back the block up: the receiver stops while the sender keeps offering
      if (ph == 3 || ph == 7) begin
        @(posedge clk);
        hold_token <= hold_token + 1;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pending_ticks = {pending_ticks, next_random_item()};
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Drop the run if it hangs; a correct run ends far sooner
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== angle_pd_controller.f =====
sv/apd_pkg.sv
sv/apd_mul.sv
sv/apd_div.sv
sv/angle_pd_controller.sv
sv/apd_checker.sv
tb/angle_pd_controller_tb.sv
